/* rtl/aesgcm_pkg.sv */
// aesgcm_pkg: shared types, command codes and aes/ghash round functions
// used by the aes-128-gcm engine; no dependencies
package aesgcm_pkg;

    localparam int BLK_W   = 128;
    localparam int RK_NUM  = 11;
    localparam int RK_AW   = 4;
    localparam int LAST_RND = 10;

    // command codes
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic [BLK_W-1:0] z;
        logic [BLK_W-1:0] v;
    } gf_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // one aes round; byte i of the state sits at bits 127-8i
    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                  input logic [BLK_W-1:0] k,
                                                  input logic last);
        logic [7:0] sb [16];
        logic [7:0] t [16];
        logic [7:0] m [16];
        logic [7:0] all;
        logic [BLK_W-1:0] o;
        for (int i = 0; i < 16; i++) begin
            sb[i] = s[BLK_W-1-8*i -: 8];
        end
        // sub bytes and shift rows
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = SBOX[sb[4*((c+r)%4)+r]];
            end
        end
        // mix columns
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
        end
        for (int i = 0; i < 16; i++) begin
            o[BLK_W-1-8*i -: 8] = last ? t[i] : m[i];
        end
        aes_round = o ^ k;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // next round key from the previous one
    function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] k,
                                                 input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'd0};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        key_step = {n0, n1, n2, n3};
    endfunction

    // eight steps of the gcm shift-and-add multiply, top bit of x first
    function automatic gf_t gf_mul8(input gf_t g, input logic [7:0] x);
        gf_t o;
        logic carry;
        o = g;
        for (int i = 7; i >= 0; i--) begin
            if (x[i]) begin
                o.z = o.z ^ o.v;
            end
            carry = o.v[0];
            o.v = {1'b0, o.v[BLK_W-1:1]};
            if (carry) begin
                o.v[BLK_W-1 -: 8] = o.v[BLK_W-1 -: 8] ^ 8'he1;
            end
        end
        gf_mul8 = o;
    endfunction

endpackage

/* rtl/aes128_gcm_engine.sv */
// aes128_gcm_engine: aes-128-gcm with 96-bit nonce and no aad
// depends on aesgcm_pkg for the round, key step and ghash functions
//
// usage: write the key through cfg_we/cfg_index/cfg_data while idle, then send
// a start item (nonce, direction), data items and a finish item on the input
// channel (in_valid/in_ready). Results leave on out_valid/out_ready.
// start: the item is accepted, then key expansion runs at one round a cycle,
// which also derives the hash subkey; no result. data: the item is accepted,
// then aes rounds with round keys read from the key memory one per cycle,
// then ghash at 8 bits a cycle, then the output register is loaded. finish:
// the item is accepted, then ghash of the length block, the aes rounds for
// the tag and the output load.
// out-of-order items and empty data blocks go straight to the output load.
// the next item is taken while a result still waits in the output register;
// a new result waits until the receiver takes the old one.
// reset clears the control state and the key registers; the round key
// memory holds garbage until the first start item.
module aes128_gcm_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic        decrypt,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic [4:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    output logic        result_kind,
    output logic [4:0]  result_bytes,
    output logic        tag_match,
    output logic        order_error
);
    import aesgcm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_KEY, S_ENC, S_MUL, S_OUT} state_t;

    state_t            state_reg;
    logic [3:0]        rnd_reg;
    logic [63:0]       key_high_reg;
    logic [63:0]       key_low_reg;
    logic [BLK_W-1:0]  key_cur_reg;
    logic [7:0]        rc_reg;
    logic [BLK_W-1:0]  s_reg;
    logic [BLK_W-1:0]  h_reg;
    logic [BLK_W-1:0]  acc_reg;
    logic [BLK_W-1:0]  z_reg;
    logic [BLK_W-1:0]  v_reg;
    logic [BLK_W-1:0]  x_reg;
    logic [BLK_W-1:0]  enc_in_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [BLK_W-1:0]  mask_reg;
    logic [4:0]        nb_reg;
    logic [95:0]       nonce_reg;
    logic [31:0]       ctr_reg;
    logic [35:0]       bt_reg;
    logic              dec_reg;
    logic              in_msg_reg;
    logic              partial_reg;
    logic              fin_reg;
    logic [BLK_W-1:0]  res_reg;
    logic              res_kind_reg;
    logic [4:0]        res_bytes_reg;
    logic              res_match_reg;
    logic              res_err_reg;
    logic              out_valid_reg;
    logic [BLK_W-1:0]  out_data_reg;
    logic              out_kind_reg;
    logic [4:0]        out_bytes_reg;
    logic              out_match_reg;
    logic              out_err_reg;

    // round key memory
    logic [BLK_W-1:0]  rk_mem [RK_NUM];
    logic [BLK_W-1:0]  rk_q;
    logic [RK_AW-1:0]  rd_addr;
    logic              wr_en;
    logic [RK_AW-1:0]  wr_addr;
    logic [BLK_W-1:0]  wr_data;

    logic [BLK_W-1:0]  key_in;
    logic [BLK_W-1:0]  key_nxt;
    logic [BLK_W-1:0]  s_nxt;
    logic [BLK_W-1:0]  blk_in;
    logic [4:0]        nb_clamp;
    logic [BLK_W-1:0]  mask_in;
    logic [BLK_W-1:0]  data_res;
    logic [BLK_W-1:0]  tag;
    gf_t               g_nxt;
    gf_t               g_cur;

    assign key_in   = {key_high_reg, key_low_reg};
    assign key_nxt  = key_step(key_cur_reg, rc_reg);
    assign blk_in   = {block_high, block_low};
    assign nb_clamp = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
    assign mask_in  = ~({BLK_W{1'b0}}) << {(5'd16 - nb_clamp), 3'b000};
    assign in_ready = (state_reg == S_IDLE);

    // round datapath shared by key expansion and block encryption
    always_comb
    begin
        if (state_reg == S_KEY) begin
            s_nxt = aes_round(s_reg, key_nxt, rnd_reg == 4'(LAST_RND));
        end else if (rnd_reg == 4'd0) begin
            s_nxt = enc_in_reg ^ rk_q;
        end else begin
            s_nxt = aes_round(s_reg, rk_q, rnd_reg == 4'(LAST_RND));
        end
    end

    assign data_res = (blk_reg ^ s_nxt) & mask_reg;
    assign tag      = s_nxt ^ acc_reg;
    assign g_cur.z  = z_reg;
    assign g_cur.v  = v_reg;
    assign g_nxt    = gf_mul8(g_cur, x_reg[BLK_W-1 -: 8]);

    // memory addressing: round keys read one ahead, key zero otherwise
    always_comb
    begin
        if (state_reg == S_ENC && rnd_reg != 4'(LAST_RND)) begin
            rd_addr = rnd_reg + 4'd1;
        end else begin
            rd_addr = '0;
        end
        wr_en   = 1'b0;
        wr_addr = rnd_reg;
        wr_data = key_nxt;
        if (state_reg == S_IDLE && in_valid && command == CMD_START) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = key_in;
        end else if (state_reg == S_KEY) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            rk_mem[wr_addr] <= wr_data;
        end
        rk_q <= rk_mem[rd_addr];
    end

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            if (cfg_index) begin
                key_low_reg <= cfg_data;
            end else begin
                key_high_reg <= cfg_data;
            end
        end
    end

    // sequencer and message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            rnd_reg       <= '0;
            acc_reg       <= '0;
            ctr_reg       <= '0;
            bt_reg        <= '0;
            dec_reg       <= 1'b0;
            in_msg_reg    <= 1'b0;
            partial_reg   <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid) begin
                        res_reg       <= '0;
                        res_kind_reg  <= 1'b0;
                        res_bytes_reg <= '0;
                        res_match_reg <= 1'b0;
                        res_err_reg   <= 1'b0;
                        rnd_reg       <= '0;
                        blk_reg       <= blk_in;
                        if (command == CMD_START) begin
                            key_cur_reg <= key_in;
                            s_reg       <= key_in;
                            rc_reg      <= 8'h01;
                            rnd_reg     <= 4'd1;
                            nonce_reg   <= {block_high, block_low[63:32]};
                            ctr_reg     <= 32'd1;
                            acc_reg     <= '0;
                            bt_reg      <= '0;
                            dec_reg     <= decrypt;
                            in_msg_reg  <= 1'b1;
                            partial_reg <= 1'b0;
                            state_reg   <= S_KEY;
                        end else if (command == CMD_DATA && in_msg_reg && !partial_reg) begin
                            if (valid_bytes == 5'd0) begin
                                state_reg <= S_OUT;
                            end else begin
                                nb_reg     <= nb_clamp;
                                mask_reg   <= mask_in;
                                ctr_reg    <= ctr_reg + 32'd1;
                                enc_in_reg <= {nonce_reg, ctr_reg + 32'd1};
                                fin_reg    <= 1'b0;
                                state_reg  <= S_ENC;
                            end
                        end else if (command == CMD_FINISH && in_msg_reg) begin
                            fin_reg   <= 1'b1;
                            z_reg     <= '0;
                            v_reg     <= h_reg;
                            x_reg     <= acc_reg ^ {89'd0, bt_reg, 3'b000};
                            state_reg <= S_MUL;
                        end else begin
                            res_err_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end
                    end
                end
                S_KEY:
                begin
                    key_cur_reg <= key_nxt;
                    rc_reg      <= xtime(rc_reg);
                    s_reg       <= s_nxt;
                    rnd_reg     <= rnd_reg + 4'd1;
                    if (rnd_reg == 4'(LAST_RND)) begin
                        h_reg     <= s_nxt;
                        rnd_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_ENC:
                begin
                    s_reg   <= s_nxt;
                    rnd_reg <= rnd_reg + 4'd1;
                    if (rnd_reg == 4'(LAST_RND)) begin
                        rnd_reg <= '0;
                        if (fin_reg) begin
                            res_reg       <= tag;
                            res_kind_reg  <= 1'b1;
                            res_bytes_reg <= 5'd16;
                            res_match_reg <= dec_reg && (tag == blk_reg);
                            in_msg_reg    <= 1'b0;
                            partial_reg   <= 1'b0;
                            state_reg     <= S_OUT;
                        end else begin
                            res_reg       <= data_res;
                            res_bytes_reg <= nb_reg;
                            bt_reg        <= bt_reg + 36'(nb_reg);
                            if (nb_reg != 5'd16) begin
                                partial_reg <= 1'b1;
                            end
                            z_reg <= '0;
                            v_reg <= h_reg;
                            x_reg <= acc_reg ^ (dec_reg ? (blk_reg & mask_reg) : data_res);
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    z_reg   <= g_nxt.z;
                    v_reg   <= g_nxt.v;
                    x_reg   <= {x_reg[BLK_W-9:0], 8'd0};
                    rnd_reg <= rnd_reg + 4'd1;
                    if (rnd_reg == 4'd15) begin
                        acc_reg <= g_nxt.z;
                        rnd_reg <= '0;
                        if (fin_reg) begin
                            enc_in_reg <= {nonce_reg, 32'd1};
                            state_reg  <= S_ENC;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        out_kind_reg  <= res_kind_reg;
                        out_bytes_reg <= res_bytes_reg;
                        out_match_reg <= res_match_reg;
                        out_err_reg   <= res_err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_high  = out_data_reg[127:64];
    assign result_low   = out_data_reg[63:0];
    assign result_kind  = out_kind_reg;
    assign result_bytes = out_bytes_reg;
    assign tag_match    = out_match_reg;
    assign order_error  = out_err_reg;

endmodule
